[hdl/arm_thumb_next_pc_predictor_top_defines.svh]
// Assertion macros for the next-PC predictor checker.
// No dependencies; taken in by the checker file only.
`ifndef ARM_THUMB_NEXT_PC_PREDICTOR_TOP_DEFINES_SVH
`define ARM_THUMB_NEXT_PC_PREDICTOR_TOP_DEFINES_SVH

// Implication checked in the same cycle; the consequent may carry a delay.
`define ATNPP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ATNPP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/atnpp_pkg.sv]
// Shared types, decode constants and the condition check for the next-PC predictor.
// No dependencies.
`timescale 1ns / 1ps

package atnpp_pkg;

   localparam logic [15:0] T_B_MASK     = 16'hF800;
   localparam logic [15:0] T_B_MATCH    = 16'hE000;
   localparam logic [15:0] T_BCOND_MASK = 16'hF000;
   localparam logic [15:0] T_BCOND_MATCH = 16'hD000;
   localparam logic [15:0] T_BW_MATCH   = 16'hF000;
   localparam logic [15:0] T_BW2_MASK   = 16'h9000;
   localparam logic [15:0] T_BX_MASK    = 16'hFF00;
   localparam logic [15:0] T_BX_MATCH   = 16'h4700;
   localparam logic [15:0] T_WIDE_MASK  = 16'hE000;
   localparam logic [31:0] A_B_MASK     = 32'h0E00_0000;
   localparam logic [31:0] A_B_MATCH    = 32'h0A00_0000;

   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [2:0] SIZE_WORD = 3'd4;
   localparam logic [3:0] T_PC_AHEAD = 4'd4;
   localparam logic [3:0] A_PC_AHEAD = 4'd8;

   typedef enum logic [3:0] {
      COND_EQ, COND_NE, COND_CS, COND_CC, COND_MI, COND_PL, COND_VS, COND_VC,
      COND_HI, COND_LS, COND_GE, COND_LT, COND_GT, COND_LE, COND_AL, COND_NV
   } cond_type;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] cur_pc;
      logic        thumb_mode;
      logic [3:0]  nzcv_flags;
   } req_type;

   typedef struct packed {
      logic [31:0] next_addr;
      logic        is_branch;
      logic        branch_taken;
      logic        unpredictable;
      logic [2:0]  instr_size;
   } dec_result_type;

   // flags: N bit 3, Z bit 2, C bit 1, V bit 0
   function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] flags);
      logic n, z, c, v, res;
      n = flags[3];
      z = flags[2];
      c = flags[1];
      v = flags[0];
      case (cond_type'(cond))
         COND_EQ: res = z;
         COND_NE: res = !z;
         COND_CS: res = c;
         COND_CC: res = !c;
         COND_MI: res = n;
         COND_PL: res = !n;
         COND_VS: res = v;
         COND_VC: res = !v;
         COND_HI: res = c && !z;
         COND_LS: res = !c || z;
         COND_GE: res = (n == v);
         COND_LT: res = (n != v);
         COND_GT: res = !z && (n == v);
         COND_LE: res = z || (n != v);
         COND_AL: res = 1'b1;
         default: res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

[hdl/atnpp_decode.sv]
// Branch decode and next-address adder, one item in one pass of logic.
// Depends on atnpp_pkg.
`timescale 1ns / 1ps

module atnpp_decode (
   input  atnpp_pkg::req_type        req,
   output atnpp_pkg::dec_result_type res
);

   logic [15:0] hw;
   logic [15:0] hw2;
   logic        s_bit;
   logic        i1;
   logic        i2;
   logic [31:0] offset;
   logic [3:0]  ahead;
   logic [31:0] addend;
   logic        taken;

   assign hw    = req.instr_word[15:0];
   assign hw2   = req.instr_word[31:16];
   assign s_bit = hw[10];
   assign i1    = ~(hw2[13] ^ s_bit);
   assign i2    = ~(hw2[11] ^ s_bit);

   always_comb begin
      res.is_branch     = 1'b0;
      res.unpredictable = 1'b0;
      res.instr_size    = atnpp_pkg::SIZE_WORD;
      taken             = 1'b0;
      offset            = 32'd0;
      ahead             = atnpp_pkg::T_PC_AHEAD;
      if (req.thumb_mode) begin
         if ((hw & atnpp_pkg::T_B_MASK) == atnpp_pkg::T_B_MATCH) begin
            res.is_branch  = 1'b1;
            res.instr_size = atnpp_pkg::SIZE_HALF;
            taken          = 1'b1;
            offset         = {{20{hw[10]}}, hw[10:0], 1'b0};
         end else if ((hw & atnpp_pkg::T_BCOND_MASK) == atnpp_pkg::T_BCOND_MATCH) begin
            res.is_branch  = 1'b1;
            res.instr_size = atnpp_pkg::SIZE_HALF;
            taken          = atnpp_pkg::cond_holds(hw[11:8], req.nzcv_flags);
            offset         = {{23{hw[7]}}, hw[7:0], 1'b0};
         end else if (((hw & atnpp_pkg::T_B_MASK) == atnpp_pkg::T_BW_MATCH) &&
                      ((hw2 & atnpp_pkg::T_BW2_MASK) == atnpp_pkg::T_BW2_MASK)) begin
            res.is_branch = 1'b1;
            taken         = 1'b1;
            offset        = {{7{s_bit}}, s_bit, i1, i2, hw[9:0], hw2[10:0], 1'b0};
         end else if ((hw & atnpp_pkg::T_BX_MASK) == atnpp_pkg::T_BX_MATCH) begin
            res.unpredictable = 1'b1;
            res.instr_size    = atnpp_pkg::SIZE_HALF;
         end else if ((hw & atnpp_pkg::T_WIDE_MASK) != atnpp_pkg::T_WIDE_MASK) begin
            res.instr_size = atnpp_pkg::SIZE_HALF;
         end
      end else begin
         ahead = atnpp_pkg::A_PC_AHEAD;
         if ((req.instr_word & atnpp_pkg::A_B_MASK) == atnpp_pkg::A_B_MATCH) begin
            res.is_branch = 1'b1;
            taken = atnpp_pkg::cond_holds(req.instr_word[31:28], req.nzcv_flags);
            offset = {{6{req.instr_word[23]}}, req.instr_word[23:0], 2'b00};
         end
      end
      // not taken: fall through by the instruction length
      addend = taken ? offset : 32'd0;
      if (!taken) begin
         ahead = {1'b0, res.instr_size};
      end
      res.branch_taken = taken;
      res.next_addr    = req.cur_pc + addend + {28'd0, ahead};
   end

endmodule

[hdl/arm_thumb_next_pc_predictor_top.sv]
// Top level of the next-PC predictor: input register, decode, result register.
// Depends on atnpp_pkg and atnpp_decode.
`timescale 1ns / 1ps

// Next-PC predictor for single-stepping ARM and Thumb code.
// Request channel: drive req_* and raise start; the item is taken at a rising
// edge where start is high and busy is low. busy is high only during reset and
// until the first edge with reset low, so an item may be issued every cycle.
// Result channel: rsp_valid is high for exactly one cycle with the rsp_*
// fields; there is no back-pressure, the receiver must take it then.
// Path: an item taken at an edge is stored in the input register, decoded
// and added in one pass, and held in the result register, which drives
// rsp_valid and the rsp_* fields.
// Throughput: one item per cycle, set by the single decode/adder pass between
// the two registers.
// Reset (synchronous, active high) clears the valid flags, so no result
// is shown for items in flight when reset hits.
// Thumb BX/BLX Rm is flagged unpredictable and the fall-through is given.
module arm_thumb_next_pc_predictor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_cur_pc,
   input  logic        req_thumb_mode,
   input  logic [3:0]  req_nzcv_flags,
   output logic        rsp_valid,
   output logic [31:0] rsp_next_addr,
   output logic        rsp_is_branch,
   output logic        rsp_branch_taken,
   output logic        rsp_unpredictable,
   output logic [2:0]  rsp_instr_size
);

   atnpp_pkg::req_type        req_ff;
   atnpp_pkg::req_type        req_in;
   atnpp_pkg::dec_result_type res_ff;
   atnpp_pkg::dec_result_type res_in;
   logic                      req_valid_ff;
   logic                      req_valid_in;
   logic                      res_valid_ff;
   logic                      busy_ff;

   assign req_valid_in = start && !busy_ff;
   assign req_in = '{instr_word: req_instr_word, cur_pc: req_cur_pc,
                     thumb_mode: req_thumb_mode, nzcv_flags: req_nzcv_flags};

   atnpp_decode u_decode (
      .req (req_ff),
      .res (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
         busy_ff      <= 1'b1;
      end else begin
         req_valid_ff <= req_valid_in;
         res_valid_ff <= req_valid_ff;
         busy_ff      <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
      if (req_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign busy              = busy_ff;
   assign rsp_valid         = res_valid_ff;
   assign rsp_next_addr     = res_ff.next_addr;
   assign rsp_is_branch     = res_ff.is_branch;
   assign rsp_branch_taken  = res_ff.branch_taken;
   assign rsp_unpredictable = res_ff.unpredictable;
   assign rsp_instr_size    = res_ff.instr_size;

endmodule

[hdl/atnpp_checker.sv]
// Port-level checks for the next-PC predictor, bound to the top level.
// Depends on arm_thumb_next_pc_predictor_top_defines.svh.
`timescale 1ns / 1ps
`include "arm_thumb_next_pc_predictor_top_defines.svh"

module atnpp_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_is_branch,
   input logic       rsp_branch_taken,
   input logic       rsp_unpredictable,
   input logic [2:0] rsp_instr_size
);

   // every accepted item comes out, with rsp_valid high, after the two registers
   `ATNPP_ASSERT_NOW(a_item_out, clock, reset, start && !busy, ##2 rsp_valid, "item lost")
   `ATNPP_ASSERT_NEXT(a_no_spurious, clock, reset, !(start && !busy), ##1 !rsp_valid || $past(reset), "result without item")
   `ATNPP_ASSERT_NOW(a_taken_branch, clock, reset, rsp_valid && !rsp_is_branch, !rsp_branch_taken, "taken without branch")
   `ATNPP_ASSERT_NOW(a_size, clock, reset, rsp_valid, rsp_instr_size == 3'd2 || rsp_instr_size == 3'd4, "bad size")
   `ATNPP_ASSERT_NOW(a_unpred, clock, reset, rsp_valid && rsp_unpredictable, !rsp_is_branch && rsp_instr_size == 3'd2, "bad register branch")

endmodule

bind arm_thumb_next_pc_predictor_top atnpp_checker u_atnpp_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_is_branch     (rsp_is_branch),
   .rsp_branch_taken  (rsp_branch_taken),
   .rsp_unpredictable (rsp_unpredictable),
   .rsp_instr_size    (rsp_instr_size)
);

[test/tb_top.sv]
// Self-checking bench for arm_thumb_next_pc_predictor_top: directed and random ARM/Thumb items.
// Depends on atnpp_pkg for request/result types, decode masks and condition names.
`timescale 1ns / 1ps

module tb_top;
   import atnpp_pkg::*;

   localparam int DRAIN_CYCLES   = 4;
   localparam int STALL_LIMIT    = 500;
   localparam int RANDOM_ITEMS   = 1450;
   localparam int MAX_REPORTS    = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_instr_word = '0;
   logic [31:0] req_cur_pc = '0;
   logic        req_thumb_mode = 1'b0;
   logic [3:0]  req_nzcv_flags = '0;
   logic        rsp_valid;
   logic [31:0] rsp_next_addr;
   logic        rsp_is_branch;
   logic        rsp_branch_taken;
   logic        rsp_unpredictable;
   logic [2:0]  rsp_instr_size;

   dec_result_type expected_pcs[$];
   int  mismatch_count = 0;
   int  stall_cycles = 0;
   bit  no_idle = 1'b0;

   arm_thumb_next_pc_predictor_top uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_instr_word    (req_instr_word),
      .req_cur_pc        (req_cur_pc),
      .req_thumb_mode    (req_thumb_mode),
      .req_nzcv_flags    (req_nzcv_flags),
      .rsp_valid         (rsp_valid),
      .rsp_next_addr     (rsp_next_addr),
      .rsp_is_branch     (rsp_is_branch),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_unpredictable (rsp_unpredictable),
      .rsp_instr_size    (rsp_instr_size)
   );

   always #5 clock = ~clock;

   function automatic bit flags_pass(input logic [3:0] cond, input logic [3:0] nzcv);
      bit n, z, c, v;
      n = nzcv[3];
      z = nzcv[2];
      c = nzcv[1];
      v = nzcv[0];
      case (cond_type'(cond))
         COND_EQ: return z;
         COND_NE: return !z;
         COND_CS: return c;
         COND_CC: return !c;
         COND_MI: return n;
         COND_PL: return !n;
         COND_VS: return v;
         COND_VC: return !v;
         COND_HI: return c && !z;
         COND_LS: return !c || z;
         COND_GE: return n == v;
         COND_LT: return n != v;
         COND_GT: return !z && (n == v);
         COND_LE: return z || (n != v);
         COND_AL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic dec_result_type predict_next_pc(input req_type item);
      dec_result_type r;
      logic [15:0] hw, hw2;
      logic        s, i1, i2;
      logic [31:0] offset;
      hw  = item.instr_word[15:0];
      hw2 = item.instr_word[31:16];
      r = '0;
      if (item.thumb_mode) begin
         r.instr_size = SIZE_HALF;
         if ((hw & T_B_MASK) == T_B_MATCH) begin
            offset = {{20{hw[10]}}, hw[10:0], 1'b0};
            r.is_branch = 1'b1;
            r.branch_taken = 1'b1;
            r.next_addr = item.cur_pc + 32'(T_PC_AHEAD) + offset;
         end else if ((hw & T_BCOND_MASK) == T_BCOND_MATCH) begin
            r.is_branch = 1'b1;
            if (flags_pass(hw[11:8], item.nzcv_flags)) begin
               offset = {{23{hw[7]}}, hw[7:0], 1'b0};
               r.branch_taken = 1'b1;
               r.next_addr = item.cur_pc + 32'(T_PC_AHEAD) + offset;
            end else begin
               r.next_addr = item.cur_pc + 32'(SIZE_HALF);
            end
         end else if ((hw & T_B_MASK) == T_BW_MATCH && (hw2 & T_BW2_MASK) == T_BW2_MASK) begin
            s  = hw[10];
            i1 = ~(hw2[13] ^ s);
            i2 = ~(hw2[11] ^ s);
            offset = {{7{s}}, s, i1, i2, hw[9:0], hw2[10:0], 1'b0};
            r.is_branch = 1'b1;
            r.branch_taken = 1'b1;
            r.instr_size = SIZE_WORD;
            r.next_addr = item.cur_pc + 32'(T_PC_AHEAD) + offset;
         end else if ((hw & T_BX_MASK) == T_BX_MATCH) begin
            r.unpredictable = 1'b1;
            r.next_addr = item.cur_pc + 32'(SIZE_HALF);
         end else begin
            if ((hw & T_WIDE_MASK) == T_WIDE_MASK)
               r.instr_size = SIZE_WORD;
            r.next_addr = item.cur_pc + 32'(r.instr_size);
         end
      end else begin
         r.instr_size = SIZE_WORD;
         r.next_addr = item.cur_pc + 32'(SIZE_WORD);
         if ((item.instr_word & A_B_MASK) == A_B_MATCH) begin
            r.is_branch = 1'b1;
            if (flags_pass(item.instr_word[31:28], item.nzcv_flags)) begin
               offset = {{6{item.instr_word[23]}}, item.instr_word[23:0], 2'b00};
               r.branch_taken = 1'b1;
               r.next_addr = item.cur_pc + 32'(A_PC_AHEAD) + offset;
            end
         end
      end
      return r;
   endfunction

   // Drives one item at the falling edge and holds it until taken.
   task automatic send_item(input req_type item);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      req_instr_word <= item.instr_word;
      req_cur_pc     <= item.cur_pc;
      req_thumb_mode <= item.thumb_mode;
      req_nzcv_flags <= item.nzcv_flags;
      start          <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      expected_pcs.push_back(predict_next_pc(item));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_pcs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_pc();
      case ($urandom_range(0, 9))
         0:       return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
         1:       return 32'($urandom_range(0, 255));
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_item();
      req_type     item;
      logic [15:0] hw, hw2;
      int          pick;
      pick = $urandom_range(0, 99);
      hw2  = 16'($urandom());
      hw   = 16'($urandom());
      item.cur_pc     = random_pc();
      item.nzcv_flags = 4'($urandom());
      item.thumb_mode = (pick < 55);
      if (pick < 8) begin
         hw = T_B_MATCH | {5'b0, hw[10:0]};
      end else if (pick < 22) begin
         hw = T_BCOND_MATCH | {4'b0, hw[11:0]};
      end else if (pick < 34) begin
         hw  = T_BW_MATCH | {5'b0, hw[10:0]};
         hw2 = hw2 | T_BW2_MASK;
      end else if (pick < 38) begin
         // wide branch prefix with a second halfword that is not a branch
         hw  = T_BW_MATCH | {5'b0, hw[10:0]};
         hw2 = $urandom_range(0, 1) ? (hw2 & 16'h7FFF) : (hw2 & 16'hEFFF);
      end else if (pick < 43) begin
         hw = T_BX_MATCH | {8'b0, hw[7:0]};
      end else if (pick < 48) begin
         hw = hw | T_WIDE_MASK;
      end
      item.instr_word = {hw2, hw};
      if (!item.thumb_mode) begin
         item.instr_word = $urandom();
         if (pick < 80)
            item.instr_word = (item.instr_word & ~A_B_MASK) | A_B_MATCH;
      end
      return item;
   endfunction

   task automatic test_thumb_branches();
      send_item('{32'h0000_E3FF, 32'h0000_1000, 1'b1, 4'h0});
      send_item('{32'hFFFF_E400, 32'h0000_0002, 1'b1, 4'hF});
      send_item('{32'h1234_E3FF, 32'hFFFF_FFF0, 1'b1, 4'h0});
      send_item('{32'h0000_D07F, 32'h0000_0100, 1'b1, 4'b0100});
      send_item('{32'h0000_D080, 32'h0000_0100, 1'b1, 4'b0000});
      send_item('{32'h0000_DE80, 32'h0000_0000, 1'b1, 4'h0});
      send_item('{32'h0000_DFFF, 32'h0000_2000, 1'b1, 4'hF});
      send_item('{32'h97FF_F3FF, 32'h0000_4000, 1'b1, 4'h0});
      send_item('{32'hD000_F400, 32'h0000_0004, 1'b1, 4'h0});
      send_item('{32'h8000_F000, 32'h0000_3000, 1'b1, 4'h0});
      send_item('{32'h0000_4770, 32'hFFFF_FFFE, 1'b1, 4'h0});
      send_item('{32'hF8D0_E800, 32'h0000_5000, 1'b1, 4'h0});
      send_item('{32'h0000_0000, 32'hFFFF_FFFE, 1'b1, 4'hF});
      send_item('{32'hFFFF_FFFF, 32'hFFFF_FFFC, 1'b1, 4'h0});
   endtask

   task automatic test_arm_branches();
      send_item('{32'hEA7F_FFFF, 32'h0000_0000, 1'b0, 4'h0});
      send_item('{32'hEB80_0000, 32'h0000_0010, 1'b0, 4'hF});
      send_item('{32'h0A00_0001, 32'h0000_8000, 1'b0, 4'b0100});
      send_item('{32'h0A00_0001, 32'h0000_8000, 1'b0, 4'b1011});
      send_item('{32'hFA00_0000, 32'h0000_9000, 1'b0, 4'hF});
      send_item('{32'hE3A0_0000, 32'hFFFF_FFFC, 1'b0, 4'h0});
      send_item('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 4'h5});
      send_item('{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 4'hA});
   endtask

   task automatic test_random_stream();
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         // every 40 items, pick at random between idle-free bursts and gappy stretches
         if (k % 40 == 0)
            no_idle = ($urandom_range(0, 2) == 0);
         if (k % 300 == 150)
            wait_for_results();
         send_item(random_item());
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      dec_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_pcs.size() == 0) begin
            report_mismatch("unexpected item", 32'h0, rsp_next_addr);
         end else begin
            want = expected_pcs.pop_front();
            if (rsp_next_addr !== want.next_addr)
               report_mismatch("next_addr", want.next_addr, rsp_next_addr);
            if (rsp_is_branch !== want.is_branch)
               report_mismatch("is_branch", 32'(want.is_branch), 32'(rsp_is_branch));
            if (rsp_branch_taken !== want.branch_taken)
               report_mismatch("branch_taken", 32'(want.branch_taken), 32'(rsp_branch_taken));
            if (rsp_unpredictable !== want.unpredictable)
               report_mismatch("unpredictable", 32'(want.unpredictable),
                               32'(rsp_unpredictable));
            if (rsp_instr_size !== want.instr_size)
               report_mismatch("instr_size", 32'(want.instr_size), 32'(rsp_instr_size));
         end
      end
   end

   // Stall watchdog: counts cycles in which no item moves on either side.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_thumb_branches();
      test_arm_branches();
      wait_for_results();
      test_random_stream();
      wait_for_results();
      if (mismatch_count == 0 && expected_pcs.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[arm_thumb_next_pc_predictor_top.f]
+incdir+hdl
hdl/atnpp_pkg.sv
hdl/atnpp_decode.sv
hdl/arm_thumb_next_pc_predictor_top.sv
hdl/atnpp_checker.sv
test/tb_top.sv
